[src/smip_pkg.sv]
package smip_pkg;

    localparam int LEVELS   = 12;
    localparam int LVL_W    = 4;
    localparam int LIN_FRAC = 16;
    localparam int LIN_W    = LIN_FRAC + 1;
    localparam int SUM_W    = LIN_W + 2;
    localparam int QB       = 62;
    localparam logic [63:0] T_DIV = 64'd269025;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef logic [LIN_W-1:0] lin_tab_t [256];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_RD0,
        ST_RD1,
        ST_BOX,
        ST_WAIT
    } seq_state_t;

    typedef enum logic [1:0] {
        ENC_IDLE,
        ENC_SUM,
        ENC_SRCH
    } enc_state_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[QB+63:QB];
    endfunction

    function automatic logic [63:0] pow5(input logic [63:0] s);
        logic [63:0] s2;
        logic [63:0] s4;
        s2 = qmul(s, s);
        s4 = qmul(s2, s2);
        return qmul(s4, s);
    endfunction

    function automatic logic [63:0] divfrac(input logic [63:0] n);
        logic [63:0] q;
        logic [63:0] r;
        int i;
        q = n / T_DIV;
        r = n % T_DIV;
        for (i = 0; i < QB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= T_DIV) begin
                r = r - T_DIV;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [LIN_W-1:0] lin_entry(input int c);
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] s;
        logic [63:0] cand;
        logic [63:0] lin;
        logic [63:0] v;
        int b;
        one = 64'd1 << QB;
        if (c <= 10) begin
            v = (((64'(c) * 64'd5) << LIN_FRAC) + 64'd8236) / 64'd16473;
        end else begin
            t  = divfrac(64'd1000 * 64'(c) + 64'd14025);
            t2 = qmul(t, t);
            s  = 64'd0;
            for (b = QB; b >= 0; b--) begin
                cand = s | (64'd1 << b);
                if (cand <= one && pow5(cand) <= t2) begin
                    s = cand;
                end
            end
            lin = qmul(t2, s);
            v = (lin + (64'd1 << (QB - 1 - LIN_FRAC))) >> (QB - LIN_FRAC);
        end
        return v[LIN_W-1:0];
    endfunction

    function automatic lin_tab_t build_lin_table();
        lin_tab_t tab;
        int c;
        for (c = 0; c < 256; c++) begin
            tab[c] = lin_entry(c);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

[src/smip_box.sv]
module smip_box (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] pix_a,
    input  logic [31:0] pix_b,
    input  logic [31:0] pix_c,
    input  logic [31:0] pix_d,
    output logic        done,
    output logic [31:0] box_pixel
);
    import smip_pkg::*;

    enc_state_t       state_reg;
    enc_state_t       state_next;
    logic [1:0]       ch_reg;
    logic [2:0]       step_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [7:0]       code_reg;
    logic [31:0]      pix_reg [4];
    logic [31:0]      res_reg;
    logic             done_reg;

    logic [31:0]      cur_pix;
    logic [7:0]       byte_sel;
    logic [7:0]       cand;
    logic [7:0]       lut_idx;
    logic [LIN_W-1:0] lut;
    logic             fits;
    logic [7:0]       code_new;
    logic [9:0]       alpha_sum;

    always_comb begin
        cur_pix   = pix_reg[step_reg[1:0]];
        byte_sel  = 8'(cur_pix >> {ch_reg, 3'b000});
        cand      = code_reg | (8'd1 << step_reg);
        lut_idx   = (state_reg == ENC_SUM) ? byte_sel : cand;
        lut       = LIN_TABLE[lut_idx];
        fits      = {lut, 2'b00} <= sum_reg;
        code_new  = fits ? cand : code_reg;
        alpha_sum = 10'(pix_a[31:24]) + 10'(pix_b[31:24]) + 10'(pix_c[31:24])
                  + 10'(pix_d[31:24]);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENC_IDLE: begin
                if (start) begin
                    state_next = ENC_SUM;
                end
            end
            ENC_SUM: begin
                if (step_reg == 3'd3) begin
                    state_next = ENC_SRCH;
                end
            end
            ENC_SRCH: begin
                if (step_reg == 3'd0 && ch_reg == 2'd2) begin
                    state_next = ENC_IDLE;
                end else if (step_reg == 3'd0) begin
                    state_next = ENC_SUM;
                end
            end
            default: state_next = ENC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ENC_SRCH) && (step_reg == 3'd0) && (ch_reg == 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ENC_IDLE: begin
                if (start) begin
                    pix_reg[0]     <= pix_a;
                    pix_reg[1]     <= pix_b;
                    pix_reg[2]     <= pix_c;
                    pix_reg[3]     <= pix_d;
                    res_reg[31:24] <= alpha_sum[9:2];
                    ch_reg         <= 2'd0;
                    step_reg       <= 3'd0;
                    sum_reg        <= '0;
                end
            end
            ENC_SUM: begin
                sum_reg <= sum_reg + SUM_W'(lut);
                if (step_reg == 3'd3) begin
                    step_reg <= 3'd7;
                    code_reg <= 8'd0;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
            ENC_SRCH: begin
                code_reg <= code_new;
                if (step_reg == 3'd0) begin
                    res_reg[{ch_reg, 3'b000} +: 8] <= code_new;
                    ch_reg  <= ch_reg + 2'd1;
                    sum_reg <= '0;
                end else begin
                    step_reg <= step_reg - 3'd1;
                end
            end
            default: ;
        endcase
    end

    assign done      = done_reg;
    assign box_pixel = res_reg;

endmodule

[src/srgb_mip_chain_box_filter.sv]
// Gamma-correct mip chain generator for RGBA8 images.
// Write the base width (index 0) and height (index 1) on the cfg port while
// the block is idle; any such write restarts the frame at pixel (0,0) of
// every level. Base pixels then enter on the s_ channel in raster order.
// Each input beat produces its level 0 echo and, when it completes a 2x2
// block, one pixel of the next level, which may cascade further down the
// chain. The m_ channel carries one result pixel per beat with its level,
// position, a flag on the final beat caused by the input and a flag for
// the 1x1 level.
// The taken input is registered in p_reg and, once the output register is free, loaded into it as the level 0 beat.
// Each further level takes two row buffer reads and a box unit that
// works through the three color channels one table lookup per cycle, four
// for the linear sum and eight for the binary search back to sRGB.
// One input is processed at a time, so s_ready stays low until the last
// result of the previous input has been loaded into the output register.
// An input that makes only its level 0 beat goes from ST_EMIT straight back to ST_IDLE.
// A stalled receiver holds that register and stops the sequencer.
// Reset sets the size to 1x1 and all positions to zero; no clearing pass.
module srgb_mip_chain_box_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [11:0]               cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [31:0]               s_base_pixel,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [smip_pkg::LVL_W-1:0] m_mip_level,
    output logic [10:0]               m_pixel_x,
    output logic [10:0]               m_pixel_y,
    output logic [31:0]               m_pixel_value,
    output logic                      m_last_of_run,
    output logic                      m_chain_done
);
    import smip_pkg::*;

    localparam int STORE_DEPTH = 2 * MAX_WIDTH + LEVELS;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [11:0]      width_reg;
    logic [11:0]      height_reg;
    logic [XW-1:0]    col_reg [LEVELS];
    logic [YW-1:0]    row_reg [LEVELS];
    logic [31:0]      hold_reg [LEVELS];
    logic [31:0]      store_mem [STORE_DEPTH];
    logic [31:0]      rd_data_reg;
    logic [31:0]      tl_reg;
    logic [31:0]      p_reg;
    logic [LVL_W-1:0] k_reg;
    logic [XW-1:0]    cx_reg;

    logic             m_valid_reg;
    logic [LVL_W-1:0] m_level_reg;
    logic [10:0]      m_x_reg;
    logic [10:0]      m_y_reg;
    logic [31:0]      m_value_reg;
    logic             m_last_reg;
    logic             m_done_reg;

    logic [AW-1:0]    off_tab [LEVELS];
    logic [XW-1:0]    w0;
    logic [YW-1:0]    h0;
    logic [XW-1:0]    wk;
    logic [YW-1:0]    hk;
    logic [XW-1:0]    wsh;
    logic [YW-1:0]    hsh;
    logic [XW-1:0]    cur_x;
    logic [YW-1:0]    cur_y;
    logic             wide;
    logic             tall;
    logic             in_range;
    logic             do_store;
    logic             do_hold;
    logic             do_box;
    logic             out_free;
    logic             emit;
    logic [AW-1:0]    off;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             box_start;
    logic             box_done;
    logic [31:0]      box_pixel;
    logic [31:0]      bl_pix;
    logic [31:0]      tl_pix;
    logic [31:0]      tr_pix;

    always_comb begin
        off_tab[0] = '0;
        for (int j = 1; j < LEVELS; j++) begin
            off_tab[j] = off_tab[j-1] + AW'((MAX_WIDTH >> (j - 1)) + 1);
        end
    end

    always_comb begin
        if (width_reg == 12'd0) begin
            w0 = XW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w0 = XW'(MAX_WIDTH);
        end else begin
            w0 = XW'(width_reg);
        end
        if (height_reg == 12'd0) begin
            h0 = YW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h0 = YW'(MAX_HEIGHT);
        end else begin
            h0 = YW'(height_reg);
        end
        wsh   = w0 >> k_reg;
        hsh   = h0 >> k_reg;
        wk    = (wsh == '0) ? XW'(1) : wsh;
        hk    = (hsh == '0) ? YW'(1) : hsh;
        cur_x = col_reg[k_reg];
        cur_y = row_reg[k_reg];
        wide  = wk > XW'(1);
        tall  = hk > YW'(1);
        in_range = (wide || tall)
                && !(wide && cur_x >= {wk[XW-1:1], 1'b0})
                && !(tall && cur_y >= {hk[YW-1:1], 1'b0})
                && (32'(k_reg) < LEVELS - 1);
        do_store = in_range && tall && !cur_y[0];
        do_hold  = in_range && !do_store && wide && !cur_x[0];
        do_box   = in_range && !do_store && !do_hold;
        off      = off_tab[k_reg];
        out_free = !m_valid_reg || m_ready;
        emit     = (state_reg == ST_EMIT) && out_free;
        bl_pix   = wide ? hold_reg[k_reg] : p_reg;
        tl_pix   = tall ? tl_reg : bl_pix;
        tr_pix   = tall ? rd_data_reg : p_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = do_box ? ST_RD0 : ST_IDLE;
                end
            end
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_BOX;
            ST_BOX: state_next = ST_WAIT;
            ST_WAIT: begin
                if (box_done) begin
                    state_next = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = off;
        box_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = aresetn;
            ST_RD0: begin
                rd_en   = 1'b1;
                rd_addr = wide ? off + AW'(cx_reg) - AW'(1) : off;
            end
            ST_RD1: begin
                rd_en   = 1'b1;
                rd_addr = wide ? off + AW'(cx_reg) : off;
            end
            ST_BOX: box_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= 12'd1;
            height_reg  <= 12'd1;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_index == REG_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else begin
                    height_reg <= cfg_wdata;
                end
                for (int i = 0; i < LEVELS; i++) begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                end
            end else if (emit) begin
                if (cur_x + XW'(1) >= wk) begin
                    col_reg[k_reg] <= '0;
                    row_reg[k_reg] <= (cur_y + YW'(1) >= hk) ? '0 : cur_y + YW'(1);
                end else begin
                    col_reg[k_reg] <= cur_x + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            p_reg <= s_base_pixel;
            k_reg <= '0;
        end else if (state_reg == ST_WAIT && box_done) begin
            p_reg <= box_pixel;
            k_reg <= k_reg + LVL_W'(1);
        end
        if (emit) begin
            cx_reg      <= cur_x;
            m_level_reg <= k_reg;
            m_x_reg     <= 11'(cur_x);
            m_y_reg     <= 11'(cur_y);
            m_value_reg <= p_reg;
            m_last_reg  <= !do_box;
            m_done_reg  <= (wk == XW'(1)) && (hk == YW'(1));
            if (do_hold) begin
                hold_reg[k_reg] <= p_reg;
            end
        end
        if (state_reg == ST_RD1) begin
            tl_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit && do_store) begin
            store_mem[off + AW'(cur_x)] <= p_reg;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    smip_box u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (box_start),
        .pix_a     (tl_pix),
        .pix_b     (tr_pix),
        .pix_c     (bl_pix),
        .pix_d     (p_reg),
        .done      (box_done),
        .box_pixel (box_pixel)
    );

    assign m_valid       = m_valid_reg;
    assign m_mip_level   = m_level_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_value = m_value_reg;
    assign m_last_of_run = m_last_reg;
    assign m_chain_done  = m_done_reg;

endmodule
